// ----- hw/rtl/selm_pkg.sv -----
// shared types, constants and helper functions of the lock manager
package selm_pkg;

  localparam int NUM_ITEMS   = 32;
  localparam int MAX_TRANS   = 16;
  localparam int QUEUE_DEPTH = 8;

  localparam int DATA_W   = 32;
  localparam int ITEM_W   = $clog2(NUM_ITEMS);
  localparam int TRANS_W  = $clog2(MAX_TRANS);
  localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int QDEPTH   = NUM_ITEMS * (1 << QPTR_W);
  localparam logic [3:0] SITE_RESET = 4'd1;

  typedef enum logic [2:0] {
    OP_RLOCK   = 3'd0,
    OP_WLOCK   = 3'd1,
    OP_READ    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_COMMIT  = 3'd4,
    OP_ABORT   = 3'd5,
    OP_FAIL    = 3'd6,
    OP_RECOVER = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_UNREADABLE = 3'd2,
    ST_UNSAFE     = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_S    = 2'd1,
    MODE_X    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         trans;
    logic [5:0]         item;
    logic signed [31:0] write_data;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_data;
  } out_beat_t;

  typedef struct packed {
    mode_e                mode;
    logic [MAX_TRANS-1:0] holder;
    logic [CNT_W-1:0]     count;
    logic [DATA_W-1:0]    working;
    logic [DATA_W-1:0]    committed;
  } item_ent_t;

  typedef struct packed {
    logic [TRANS_W-1:0] trans;
    logic               excl;
  } qent_t;

  // may transaction t take the lock in the requested mode given current holders
  function automatic logic holding_ok(item_ent_t e, logic [TRANS_W-1:0] t, logic x);
    logic [MAX_TRANS-1:0] one;
    logic r;
    one    = '0;
    one[t] = 1'b1;
    case (e.mode)
      MODE_NONE: r = 1'b1;
      MODE_S:    r = !x || (e.holder == one);
      MODE_X:    r = e.holder[t];
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic item_ent_t grant(item_ent_t e, logic [TRANS_W-1:0] t, logic x);
    item_ent_t r;
    r = e;
    if (x) begin
      r.mode = MODE_X;
    end else if (e.mode == MODE_NONE) begin
      r.mode = MODE_S;
    end
    r.holder[t] = 1'b1;
    return r;
  endfunction

  // items stored under a site number; odd_only keeps the odd ones alone
  function automatic logic [NUM_ITEMS-1:0] stored_mask(logic [3:0] site, logic odd_only);
    logic [NUM_ITEMS-1:0] m;
    logic even;
    logic hit;
    for (int i = 0; i < NUM_ITEMS; i++) begin
      even = ((i + 1) % 2) == 0;
      hit  = (1 + ((i + 1) % 10)) == int'(site);
      m[i] = odd_only ? (!even && hit) : (even || hit);
    end
    return m;
  endfunction

endpackage

// ----- hw/rtl/selm_ram.sv -----
// generic single write, single read ram with registered read data
module selm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/selm_ctrl.sv -----
// sequencer: request handling, release sweep, queue grants, fail and recover
module selm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [3:0]                  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  selm_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output selm_pkg::out_beat_t         out_data,
  output logic                        item_we,
  output logic [selm_pkg::ITEM_W-1:0] item_waddr,
  output selm_pkg::item_ent_t         item_wdata,
  output logic [selm_pkg::ITEM_W-1:0] item_raddr,
  input  selm_pkg::item_ent_t         item_rdata,
  output logic                        q_we,
  output logic [selm_pkg::ITEM_W+selm_pkg::QPTR_W-1:0] q_waddr,
  output selm_pkg::qent_t             q_wdata,
  output logic [selm_pkg::ITEM_W+selm_pkg::QPTR_W-1:0] q_raddr,
  input  selm_pkg::qent_t             q_rdata
);
  import selm_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_IRD, S_OPX, S_QRD, S_QCHK, S_DECIDE,
    S_CRD, S_CENT, S_CQRD, S_CQCHK, S_CRES, S_CHEAD, S_SHRD, S_SHWR, S_CWB,
    S_SRD, S_SWR, S_DONE
  } state_t;

  localparam logic [ITEM_W-1:0] LAST_IDX = ITEM_W'(NUM_ITEMS - 1);

  state_t               state;
  op_e                  cur_op;
  logic [DATA_W-1:0]    wd;
  logic [TRANS_W-1:0]   t;
  logic                 x;
  logic [ITEM_W-1:0]    idx;
  item_ent_t            ent;
  logic [CNT_W-1:0]     k;
  logic [CNT_W-1:0]     n;
  logic                 qok;
  logic                 dup;
  status_e              status;
  logic [DATA_W-1:0]    rdata_r;
  logic [3:0]           site;
  logic                 site_up;
  logic [NUM_ITEMS-1:0] readable;
  logic [NUM_ITEMS-1:0] modified [MAX_TRANS];

  op_e                in_op;
  logic [ITEM_W-1:0]  idx_in;
  logic               item_bad;
  logic               trans_bad;
  logic               held;
  logic               can_grant;
  item_ent_t          rel_ent;
  item_ent_t          pop_ent;
  item_ent_t          cwb_ent;
  item_ent_t          swp_ent;
  item_ent_t          init_ent;
  logic [CNT_W-1:0]   km1;

  assign in_stall  = (state != S_IDLE);
  assign in_op     = op_e'(in_data.op);
  assign idx_in    = ITEM_W'(in_data.item - 6'd1);
  assign item_bad  = !site_up || (in_data.item == 6'd0) || (int'(in_data.item) > NUM_ITEMS);
  assign trans_bad = int'(in_data.trans) >= MAX_TRANS;
  assign km1       = k - CNT_W'(1);

  assign held      = ent.holder[t];
  assign can_grant = (held && (!x || ent.mode == MODE_X)) || (holding_ok(ent, t, x) && qok);

  always_comb begin
    rel_ent           = item_rdata;
    rel_ent.holder[t] = 1'b0;
    if (rel_ent.holder == '0) begin
      rel_ent.mode = MODE_NONE;
    end
    pop_ent       = grant(ent, q_rdata.trans, q_rdata.excl);
    pop_ent.count = ent.count - CNT_W'(1);
    cwb_ent = ent;
    if (modified[t][idx]) begin
      if (cur_op == OP_COMMIT) begin
        cwb_ent.committed = ent.working;
      end else begin
        cwb_ent.working = ent.committed;
      end
    end
    swp_ent = item_rdata;
    if (cur_op == OP_FAIL) begin
      swp_ent.mode   = MODE_NONE;
      swp_ent.holder = '0;
      swp_ent.count  = '0;
    end else begin
      swp_ent.working = item_rdata.committed;
    end
    init_ent           = '0;
    init_ent.mode      = MODE_NONE;
    init_ent.working   = DATA_W'((int'(idx) + 1) * 10);
    init_ent.committed = DATA_W'((int'(idx) + 1) * 10);
  end

  // memory port control
  always_comb begin
    item_we    = 1'b0;
    item_waddr = idx;
    item_wdata = ent;
    item_raddr = idx;
    q_we       = 1'b0;
    q_waddr    = {idx, QPTR_W'(0)};
    q_wdata    = q_rdata;
    q_raddr    = {idx, QPTR_W'(0)};
    unique case (state)
      S_INIT: begin
        item_we    = 1'b1;
        item_wdata = init_ent;
      end
      S_OPX: begin
        if (cur_op == OP_WRITE && item_rdata.holder[t] && item_rdata.mode == MODE_X) begin
          item_we            = 1'b1;
          item_wdata         = item_rdata;
          item_wdata.working = wd;
        end
      end
      S_QRD, S_CQRD, S_SHRD: begin
        q_raddr = {idx, k[QPTR_W-1:0]};
      end
      S_DECIDE: begin
        if (can_grant) begin
          item_we    = 1'b1;
          item_wdata = grant(ent, t, x);
        end else if (!dup && int'(ent.count) < QUEUE_DEPTH) begin
          item_we          = 1'b1;
          item_wdata.count = ent.count + CNT_W'(1);
          q_we             = 1'b1;
          q_waddr          = {idx, ent.count[QPTR_W-1:0]};
          q_wdata          = '{trans: t, excl: x};
        end
      end
      S_CQCHK: begin
        if (q_rdata.trans != t) begin
          q_we    = 1'b1;
          q_waddr = {idx, n[QPTR_W-1:0]};
        end
      end
      S_SHWR: begin
        q_we    = 1'b1;
        q_waddr = {idx, km1[QPTR_W-1:0]};
      end
      S_CWB: begin
        item_we    = 1'b1;
        item_wdata = cwb_ent;
      end
      S_SWR: begin
        item_we    = 1'b1;
        item_wdata = swp_ent;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx       <= '0;
      out_valid <= 1'b0;
      site      <= SITE_RESET;
      site_up   <= 1'b1;
      readable  <= stored_mask(SITE_RESET, 1'b0);
      for (int i = 0; i < MAX_TRANS; i++) begin
        modified[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        site     <= cfg_data;
        readable <= stored_mask(cfg_data, 1'b0);
      end
      unique case (state)
        S_INIT: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + ITEM_W'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur_op  <= in_op;
            wd      <= in_data.write_data;
            t       <= TRANS_W'(in_data.trans);
            x       <= (in_op == OP_WLOCK);
            idx     <= idx_in;
            status  <= ST_OK;
            rdata_r <= '0;
            unique case (in_op)
              OP_RLOCK, OP_WLOCK, OP_READ, OP_WRITE: begin
                if (item_bad) begin
                  status <= ST_UNREADABLE;
                  state  <= S_DONE;
                end else if (trans_bad) begin
                  status <= ST_UNSAFE;
                  state  <= S_DONE;
                end else if ((in_op == OP_RLOCK || in_op == OP_READ) && !readable[idx_in]) begin
                  status <= ST_UNREADABLE;
                  state  <= S_DONE;
                end else begin
                  state <= S_IRD;
                end
              end
              OP_COMMIT, OP_ABORT: begin
                idx <= '0;
                if (trans_bad) begin
                  status <= ST_UNSAFE;
                  state  <= S_DONE;
                end else begin
                  state <= S_CRD;
                end
              end
              OP_FAIL: begin
                site_up  <= 1'b0;
                readable <= '0;
                for (int i = 0; i < MAX_TRANS; i++) begin
                  modified[i] <= '0;
                end
                idx   <= '0;
                state <= S_SRD;
              end
              default: begin
                site_up  <= 1'b1;
                readable <= stored_mask(site, 1'b1);
                idx      <= '0;
                state    <= S_SRD;
              end
            endcase
          end
        end
        S_IRD: state <= S_OPX;
        S_OPX: begin
          ent <= item_rdata;
          unique case (cur_op)
            OP_READ: begin
              if (item_rdata.holder[t]) begin
                rdata_r <= item_rdata.working;
              end else begin
                status <= ST_UNSAFE;
              end
              state <= S_DONE;
            end
            OP_WRITE: begin
              if (item_rdata.holder[t] && item_rdata.mode == MODE_X) begin
                modified[t][idx] <= 1'b1;
              end else begin
                status <= ST_UNSAFE;
              end
              state <= S_DONE;
            end
            default: begin
              k     <= '0;
              qok   <= 1'b1;
              dup   <= 1'b0;
              state <= S_QRD;
            end
          endcase
        end
        S_QRD: state <= (k < ent.count) ? S_QCHK : S_DECIDE;
        S_QCHK: begin
          if (!(q_rdata.trans == t || (!x && !q_rdata.excl))) begin
            qok <= 1'b0;
          end
          if (q_rdata.trans == t && q_rdata.excl == x) begin
            dup <= 1'b1;
          end
          k     <= k + CNT_W'(1);
          state <= S_QRD;
        end
        S_DECIDE: begin
          priority if (can_grant) begin
            status <= ST_OK;
          end else if (dup) begin
            status <= ST_QUEUED;
          end else if (int'(ent.count) >= QUEUE_DEPTH) begin
            status <= ST_FULL;
          end else begin
            status <= ST_QUEUED;
          end
          state <= S_DONE;
        end
        S_CRD: state <= S_CENT;
        S_CENT: begin
          if (item_rdata.holder[t]) begin
            ent   <= rel_ent;
            k     <= '0;
            n     <= '0;
            state <= S_CQRD;
          end else begin
            ent   <= item_rdata;
            state <= S_CRES;
          end
        end
        S_CQRD: begin
          if (k < ent.count) begin
            state <= S_CQCHK;
          end else begin
            ent.count <= n;
            state     <= S_CRES;
          end
        end
        S_CQCHK: begin
          if (q_rdata.trans != t) begin
            n <= n + CNT_W'(1);
          end
          k     <= k + CNT_W'(1);
          state <= S_CQRD;
        end
        S_CRES: state <= (ent.count != '0) ? S_CHEAD : S_CWB;
        S_CHEAD: begin
          if (holding_ok(ent, q_rdata.trans, q_rdata.excl)) begin
            ent   <= pop_ent;
            k     <= CNT_W'(1);
            state <= S_SHRD;
          end else begin
            state <= S_CWB;
          end
        end
        S_SHRD: state <= (k <= ent.count) ? S_SHWR : S_CRES;
        S_SHWR: begin
          k     <= k + CNT_W'(1);
          state <= S_SHRD;
        end
        S_CWB: begin
          if (modified[t][idx]) begin
            modified[t][idx] <= 1'b0;
            if (cur_op == OP_COMMIT) begin
              readable[idx] <= 1'b1;
            end
          end
          if (idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + ITEM_W'(1);
            state <= S_CRD;
          end
        end
        S_SRD: state <= S_SWR;
        S_SWR: begin
          if (idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + ITEM_W'(1);
            state <= S_SRD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_data.status    <= status;
            out_data.read_data <= rdata_r;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result beat without finished operation");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state != S_IDLE)
    else $error("accepted beat left sequencer idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_we |-> int'(item_wdata.count) <= QUEUE_DEPTH)
    else $error("wait count beyond queue depth");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CQCHK && q_we) |-> n <= k)
    else $error("queue compaction writes ahead of its read");
`endif

endmodule

// ----- hw/rtl/shared_exclusive_lock_manager_core.sv -----
// top level of the shared/exclusive lock manager
// Per-site lock table with strict two-phase locking. Each item keeps a lock
// mode, a holder mask, a wait count and its working and committed values in
// one item ram; wait queues live in a second ram, one row of queue slots per
// item. One beat is handled at a time and always yields one result beat.
// Each ram has a single read port, so an operation is worked through in
// steps: a read or write reads and updates its item; a lock request reads
// its item and then scans each queued entry of that item. Commit and abort
// sweep every item, dropping the transaction from the holders and the queue
// of each item it held and granting queue heads that can now take the lock.
// Fail and recover sweep every item as well. After reset the item ram is
// filled with its initial values before the first input beat is taken;
// configuration writes are taken meanwhile. The site_number register is to
// be written only while idle; the block itself does not enforce this. A
// write recomputes which items are readable in that same cycle. A result
// beat waits in the output register until taken; the next input beat is
// still accepted meanwhile, and its result waits until the register is free.
module shared_exclusive_lock_manager_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  selm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output selm_pkg::out_beat_t out_data
);
  import selm_pkg::*;

  // item table port signals
  logic                       item_we;
  logic [ITEM_W-1:0]          item_waddr;
  item_ent_t                  item_wdata;
  logic [ITEM_W-1:0]          item_raddr;
  item_ent_t                  item_rdata;

  // wait queue port signals, address is {item, slot}
  logic                       q_we;
  logic [ITEM_W+QPTR_W-1:0]   q_waddr;
  qent_t                      q_wdata;
  logic [ITEM_W+QPTR_W-1:0]   q_raddr;
  qent_t                      q_rdata;

  selm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .item_we    (item_we),
    .item_waddr (item_waddr),
    .item_wdata (item_wdata),
    .item_raddr (item_raddr),
    .item_rdata (item_rdata),
    .q_we       (q_we),
    .q_waddr    (q_waddr),
    .q_wdata    (q_wdata),
    .q_raddr    (q_raddr),
    .q_rdata    (q_rdata)
  );

  // lock state and values of every item
  selm_ram #(
    .WIDTH ($bits(item_ent_t)),
    .DEPTH (NUM_ITEMS)
  ) u_item_ram (
    .clk   (clk),
    .we    (item_we),
    .waddr (item_waddr),
    .wdata (item_wdata),
    .raddr (item_raddr),
    .rdata (item_rdata)
  );

  // fifo wait queues, only slots below the item's count are ever used
  selm_ram #(
    .WIDTH ($bits(qent_t)),
    .DEPTH (QDEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench of the shared/exclusive lock manager core
module testbench;
  import selm_pkg::*;

  localparam int NI = NUM_ITEMS;
  localparam int NT = MAX_TRANS;
  localparam int QD = QUEUE_DEPTH;
  localparam int STALL_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [3:0] cfg_data = 4'd0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  shared_exclusive_lock_manager_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // shadow lock table
  mode_e       lk_mode [NI];
  logic [NT-1:0] lk_holders [NI];
  logic [4:0]  waiters [NI][QD];
  int          wait_len [NI];
  bit          rd_ok [NI];
  logic [31:0] work_val [NI];
  logic [31:0] commit_val [NI];
  logic [NI-1:0] dirty [NT];
  bit          site_alive;
  logic [3:0]  site_id;

  out_beat_t   pending_results [$];
  int          mismatches = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          quiet_cycles = 0;

  function automatic bit stored_here(int idx);
    int n;
    n = idx + 1;
    return (n % 2 == 0) || (1 + n % 10 == int'(site_id));
  endfunction

  function automatic bit may_hold(int i, int t, bit x);
    case (lk_mode[i])
      MODE_NONE: return 1'b1;
      MODE_S:    return !x || lk_holders[i] == (NT'(1) << t);
      MODE_X:    return lk_holders[i][t];
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit queue_clear(int i, int t, bit x);
    for (int k = 0; k < wait_len[i]; k++) begin
      if (int'(waiters[i][k][4:1]) == t || (!x && !waiters[i][k][0])) continue;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_lock(int i, int t, bit x);
    if (x) lk_mode[i] = MODE_X;
    else if (lk_mode[i] == MODE_NONE) lk_mode[i] = MODE_S;
    lk_holders[i][t] = 1'b1;
  endfunction

  function automatic status_e lock_request(int i, int t, bit x);
    bit held;
    logic [4:0] ent;
    held = lk_holders[i][t];
    ent = {4'(t), x};
    if ((held && (!x || lk_mode[i] == MODE_X)) || (may_hold(i, t, x) && queue_clear(i, t, x))) begin
      take_lock(i, t, x);
      return ST_OK;
    end
    for (int k = 0; k < wait_len[i]; k++)
      if (waiters[i][k] == ent) return ST_QUEUED;
    if (wait_len[i] >= QD) return ST_FULL;
    waiters[i][wait_len[i]] = ent;
    wait_len[i]++;
    return ST_QUEUED;
  endfunction

  function automatic void release_all(int t);
    int n;
    for (int i = 0; i < NI; i++) begin
      if (!lk_holders[i][t]) continue;
      lk_holders[i][t] = 1'b0;
      n = 0;
      for (int k = 0; k < wait_len[i]; k++)
        if (int'(waiters[i][k][4:1]) != t) begin
          waiters[i][n] = waiters[i][k];
          n++;
        end
      wait_len[i] = n;
      if (lk_holders[i] == '0) lk_mode[i] = MODE_NONE;
    end
  endfunction

  // keep granting queue heads until nothing moves
  function automatic void settle_queues();
    bit moved;
    int t;
    bit x;
    moved = 1'b1;
    while (moved) begin
      moved = 1'b0;
      for (int i = 0; i < NI; i++) begin
        if (wait_len[i] == 0) continue;
        t = int'(waiters[i][0][4:1]);
        x = waiters[i][0][0];
        if (!may_hold(i, t, x)) continue;
        for (int k = 0; k < QD - 1; k++) waiters[i][k] = waiters[i][k+1];
        wait_len[i]--;
        take_lock(i, t, x);
        moved = 1'b1;
      end
    end
  endfunction

  function automatic void table_reset();
    site_id = SITE_RESET;
    site_alive = 1'b1;
    for (int t = 0; t < NT; t++) dirty[t] = '0;
    for (int i = 0; i < NI; i++) begin
      lk_mode[i] = MODE_NONE;
      lk_holders[i] = '0;
      wait_len[i] = 0;
      rd_ok[i] = stored_here(i);
      work_val[i] = 32'((i + 1) * 10);
      commit_val[i] = 32'((i + 1) * 10);
    end
  endfunction

  function automatic out_beat_t lock_table_step(in_beat_t b);
    out_beat_t r;
    int t, idx;
    op_e op;
    r = '0;
    r.status = ST_OK;
    op = op_e'(b.op);
    t = int'(b.trans);
    idx = int'(b.item) - 1;
    if (b.op <= OP_WRITE) begin
      if (!site_alive || b.item < 1 || b.item > NI) r.status = ST_UNREADABLE;
      else if (t >= NT) r.status = ST_UNSAFE;
    end else if (b.op <= OP_ABORT && t >= NT) begin
      r.status = ST_UNSAFE;
    end
    if (r.status != ST_OK) return r;
    case (op)
      OP_RLOCK: r.status = rd_ok[idx] ? lock_request(idx, t, 1'b0) : ST_UNREADABLE;
      OP_WLOCK: r.status = lock_request(idx, t, 1'b1);
      OP_READ: begin
        if (!rd_ok[idx]) r.status = ST_UNREADABLE;
        else if (lk_holders[idx][t]) r.read_data = work_val[idx];
        else r.status = ST_UNSAFE;
      end
      OP_WRITE: begin
        if (lk_holders[idx][t] && lk_mode[idx] == MODE_X) begin
          dirty[t][idx] = 1'b1;
          work_val[idx] = b.write_data;
        end else begin
          r.status = ST_UNSAFE;
        end
      end
      OP_COMMIT, OP_ABORT: begin
        release_all(t);
        for (int i = 0; i < NI; i++) begin
          if (!dirty[t][i]) continue;
          if (op == OP_COMMIT) begin
            commit_val[i] = work_val[i];
            rd_ok[i] = 1'b1;
          end else begin
            work_val[i] = commit_val[i];
          end
          dirty[t][i] = 1'b0;
        end
        settle_queues();
      end
      OP_FAIL: begin
        site_alive = 1'b0;
        for (int i = 0; i < NI; i++) begin
          lk_mode[i] = MODE_NONE;
          lk_holders[i] = '0;
          wait_len[i] = 0;
          rd_ok[i] = 1'b0;
        end
        for (int k = 0; k < NT; k++) dirty[k] = '0;
      end
      default: begin
        site_alive = 1'b1;
        for (int i = 0; i < NI; i++) begin
          work_val[i] = commit_val[i];
          rd_ok[i] = stored_here(i) && ((i + 1) % 2 != 0);
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_beat_t beat(op_e op, int t, int itm, logic [31:0] wd);
    in_beat_t b;
    b.op = op;
    b.trans = 4'(t);
    b.item = 6'(itm);
    b.write_data = wd;
    return b;
  endfunction

  // send one beat, predicting its result at the accepting edge
  task automatic send_beat(in_beat_t b);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), lock_table_step(b));
  endtask

  // hold the sender until every predicted beat has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_site(int v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = 4'(v);
    @(negedge clk);
    cfg_we = 1'b0;
    site_id = 4'(v);
    for (int i = 0; i < NI; i++) rd_ok[i] = stored_here(i);
  endtask

  // receiver stall pattern
  always @(negedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat status=%0d data=%0d",
                   out_data.status, out_data.read_data);
      end else begin
        out_beat_t want;
        want = pending_results[0];
        pending_results.delete(0);
        if (out_data.status != want.status || out_data.read_data != want.read_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected status=%0d data=%0d, got status=%0d data=%0d",
                     want.status, want.read_data, out_data.status, out_data.read_data);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // corner cases: range edges, every op, queueing, full queue, site down
  task automatic test_directed();
    send_beat(beat(OP_RLOCK, 0, 0, 0));
    send_beat(beat(OP_READ, 15, 63, 0));
    send_beat(beat(OP_WRITE, 3, 33, 32'hffffffff));
    send_beat(beat(OP_WLOCK, 0, 2, 0));
    send_beat(beat(OP_WRITE, 0, 2, 32'h80000000));
    send_beat(beat(OP_READ, 0, 2, 0));
    send_beat(beat(OP_WRITE, 0, 2, 32'h7fffffff));
    for (int t = 1; t <= 9; t++) send_beat(beat(OP_WLOCK, t, 2, 0));
    send_beat(beat(OP_WLOCK, 3, 2, 0));
    send_beat(beat(OP_RLOCK, 15, 32, 0));
    send_beat(beat(OP_RLOCK, 14, 32, 0));
    send_beat(beat(OP_WLOCK, 15, 32, 0));
    send_beat(beat(OP_WLOCK, 4, 1, 0));
    send_beat(beat(OP_RLOCK, 5, 3, 0));
    send_beat(beat(OP_COMMIT, 0, 1, 0));
    send_beat(beat(OP_ABORT, 12, 1, 0));
    send_beat(beat(OP_RECOVER, 0, 1, 0));
    send_beat(beat(OP_FAIL, 0, 1, 0));
    send_beat(beat(OP_RLOCK, 1, 2, 0));
    send_beat(beat(OP_READ, 1, 2, 0));
    send_beat(beat(OP_RECOVER, 0, 1, 0));
    send_beat(beat(OP_READ, 1, 1, 0));
    drain();
  endtask

  // mostly lock/access/finish traffic on a few hot items, some noise
  task automatic test_random(int n);
    int r, t, itm;
    op_e op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 20) op = OP_RLOCK;
      else if (r < 40) op = OP_WLOCK;
      else if (r < 55) op = OP_READ;
      else if (r < 72) op = OP_WRITE;
      else if (r < 86) op = OP_COMMIT;
      else if (r < 95) op = OP_ABORT;
      else if (r < 97) op = OP_FAIL;
      else op = OP_RECOVER;
      t = ($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(15);
      itm = ($urandom_range(99) < 88) ? $urandom_range(6, 1) : $urandom_range(63);
      send_beat(beat(op, t, itm, $urandom));
    end
  endtask

  initial begin
    table_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    tx_idle_pct = 15;
    rx_idle_pct = 54;
    write_site(10);
    test_directed();
    test_random(100);
    drain();
    write_site(1);
    test_random(90);
    drain();

    tx_idle_pct = 54;
    rx_idle_pct = 15;
    write_site($urandom_range(9, 2));
    test_random(190);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_site($urandom_range(10, 1));
    test_random(190);
    drain();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
